>>> design/assert_macros.svh
// Assertion macros shared by the priority queue RTL.
// Included by every module that carries concurrent assertions; expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SMPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Trigger in a cycle implies consequence in the next.
`define SMPQ_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

>>> design/smpq_pkg.sv
// Package for the sorted minimum priority queue: payload structs, cell types, constants.
// No dependencies; used by smpq_cell and sorted_min_priority_queue.
package smpq_pkg;

  localparam int unsigned KEY_BITS      = 16;
  localparam int unsigned TAG_BITS      = 8;
  localparam int unsigned COUNT_BITS    = 5;
  localparam int unsigned DEF_QUEUE_DEPTH = 16;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } smpq_mode_t;

  typedef struct packed {
    logic                mode;
    logic [KEY_BITS-1:0] item_key;
    logic [TAG_BITS-1:0] item_tag;
  } smpq_in_t;

  typedef struct packed {
    logic                  removed_valid;
    logic [KEY_BITS-1:0]   removed_key;
    logic [TAG_BITS-1:0]   removed_tag;
    logic                  head_valid;
    logic [KEY_BITS-1:0]   head_key;
    logic [TAG_BITS-1:0]   head_tag;
    logic [COUNT_BITS-1:0] entry_count;
    logic                  insert_dropped;
  } smpq_out_t;

  // One stored slot of the queue.
  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } smpq_entry_t;

  // Broadcast to every cell for the transaction being applied this cycle.
  typedef struct packed {
    logic                ins;   // insert, queue not full
    logic                rem;   // remove, queue not empty
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } smpq_ctrl_t;

endpackage

>>> design/sorted_min_priority_queue.sv
// Sorted minimum priority queue, QUEUE_DEPTH slots held in a row of compare-and-shift cells with
// the minimum at slot 0. One transaction (insert or remove) is taken per clock while in_ready is
// high; every slot compares the incoming key in parallel and shifts by at most one place, and the
// result is registered on acceptance. in_ready is low only while a finished result waits on out_ready.
// Depends on smpq_pkg, smpq_cell and assert_macros.svh.
`include "assert_macros.svh"

module sorted_min_priority_queue
  import smpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  smpq_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output smpq_out_t out_data
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r;
  smpq_out_t     out_data_r, res;
  smpq_ctrl_t    ctrl;
  logic          accept, full, empty, is_ins, is_rem;

  smpq_entry_t q     [QUEUE_DEPTH];
  smpq_entry_t q_nxt [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] take;
  logic [QUEUE_DEPTH-1:0] valid_vec;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (cnt_r == CW'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign is_ins   = (in_data.mode == MODE_INSERT);
  assign is_rem   = (in_data.mode == MODE_REMOVE);

  assign ctrl.ins = accept && is_ins && !full;
  assign ctrl.rem = accept && is_rem && !empty;
  assign ctrl.key = in_data.item_key;
  assign ctrl.tag = in_data.item_tag;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    smpq_entry_t prev_q, next_q;
    logic        prev_take;

    if (i == 0) begin : g_head
      // Virtual slot ahead of the head: always occupied, never gives way.
      assign prev_q    = '{valid: 1'b1, key: '0, tag: '0};
      assign prev_take = 1'b0;
    end else begin : g_body
      assign prev_q    = q[i-1];
      assign prev_take = take[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_q = '{valid: 1'b0, key: '0, tag: '0};
    end else begin : g_mid
      assign next_q = q[i+1];
    end

    smpq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .prev_q    (prev_q),
      .prev_take (prev_take),
      .next_q    (next_q),
      .q         (q[i]),
      .q_nxt     (q_nxt[i]),
      .take      (take[i])
    );

    assign valid_vec[i] = q[i].valid;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.ins) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (ctrl.rem) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_comb begin
    res                = '0;
    res.removed_valid  = ctrl.rem;
    res.removed_key    = ctrl.rem ? q[0].key : '0;
    res.removed_tag    = ctrl.rem ? q[0].tag : '0;
    res.head_valid     = q_nxt[0].valid;
    res.head_key       = q_nxt[0].valid ? q_nxt[0].key : '0;
    res.head_tag       = q_nxt[0].valid ? q_nxt[0].tag : '0;
    res.entry_count    = COUNT_BITS'(cnt_nxt);
    res.insert_dropped = accept && is_ins && full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SMPQ_ASSERT(a_count_matches, $countones(valid_vec) == int'(cnt_r), "count disagrees with occupied slots")
  `SMPQ_ASSERT_NEXT(a_accept_result, accept, out_valid_r, "accepted transaction left no result")
  `SMPQ_ASSERT(a_drop_only_full, !(out_valid_r && out_data_r.insert_dropped) || (cnt_r == CW'(QUEUE_DEPTH)), "insert dropped while not full")

endmodule

>>> design/smpq_cell.sv
// One slot of the sorted queue: holds an entry, compares it against the broadcast key,
// and shifts toward or away from the head. Depends on smpq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module smpq_cell
  import smpq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  smpq_ctrl_t  ctrl,
  input  smpq_entry_t prev_q,     // neighbor nearer the head
  input  logic        prev_take,  // neighbor nearer the head gives way to the new key
  input  smpq_entry_t next_q,     // neighbor farther from the head
  output smpq_entry_t q,
  output smpq_entry_t q_nxt,
  output logic        take
);

  smpq_entry_t q_r;
  smpq_entry_t cell_nxt;

  // Equal keys stay ahead of the new entry, so strict less-than.
  assign take = !q_r.valid || (ctrl.key < q_r.key);

  always_comb begin
    cell_nxt = q_r;
    if (ctrl.ins) begin
      if (take) begin
        if (prev_take) begin
          cell_nxt = prev_q;
        end else begin
          cell_nxt.valid = 1'b1;
          cell_nxt.key   = ctrl.key;
          cell_nxt.tag   = ctrl.tag;
        end
      end
    end else if (ctrl.rem) begin
      cell_nxt = next_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else begin
      q_r <= cell_nxt;
    end
  end

  assign q     = q_r;
  assign q_nxt = cell_nxt;

  `SMPQ_ASSERT(a_cell_prefix, !q_r.valid || prev_q.valid, "valid slot behind an empty slot")
  `SMPQ_ASSERT(a_cell_sorted, !(q_r.valid && prev_q.valid) || (prev_q.key <= q_r.key), "slot keys out of order")

endmodule

>>> sim/tb_sorted_min_priority_queue.sv
// Testbench for sorted_min_priority_queue: random and directed insert/remove traffic with
// bursty input, a stalling output and a mirrored sorted array predicting every status result.
// Depends on smpq_pkg and the RTL of the queue.
`timescale 1ns / 1ps

module tb_sorted_min_priority_queue;
  import smpq_pkg::*;

  localparam int DEPTH = DEF_QUEUE_DEPTH;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  smpq_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  smpq_out_t out_data;

  sorted_min_priority_queue #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Transactions waiting to be offered, and the status results they will produce.
  smpq_in_t  offer_queue[$];
  smpq_out_t status_fifo[$];

  // Mirror of the sorted contents, slot 0 the minimum.
  logic [KEY_BITS-1:0] mirror_key[DEPTH];
  logic [TAG_BITS-1:0] mirror_tag[DEPTH];
  int                  mirror_count = 0;

  int error_count = 0;
  int taken_count = 0;
  int total_items = 0;
  int result_index = 0;

  task automatic report_error(input string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got %0h expected %0h",
                             result_index, name, got, want));
  endtask

  // Applies one accepted transaction to the mirror and queues the status it yields.
  function automatic void sort_and_report(input smpq_in_t txn);
    smpq_out_t r;
    int        i;
    r = '0;
    if (txn.mode == MODE_INSERT) begin
      if (mirror_count >= DEPTH) begin
        r.insert_dropped = 1'b1;
      end else begin
        // equal keys stay ahead of the newcomer
        i = mirror_count;
        while (i > 0 && txn.item_key < mirror_key[i-1]) begin
          mirror_key[i] = mirror_key[i-1];
          mirror_tag[i] = mirror_tag[i-1];
          i--;
        end
        mirror_key[i] = txn.item_key;
        mirror_tag[i] = txn.item_tag;
        mirror_count++;
      end
    end else if (mirror_count > 0) begin
      r.removed_valid = 1'b1;
      r.removed_key   = mirror_key[0];
      r.removed_tag   = mirror_tag[0];
      for (i = 1; i < mirror_count; i++) begin
        mirror_key[i-1] = mirror_key[i];
        mirror_tag[i-1] = mirror_tag[i];
      end
      mirror_count--;
    end
    if (mirror_count > 0) begin
      r.head_valid = 1'b1;
      r.head_key   = mirror_key[0];
      r.head_tag   = mirror_tag[0];
    end
    r.entry_count = COUNT_BITS'(mirror_count);
    status_fifo.push_back(r);
  endfunction

  function automatic void add_item(input smpq_mode_t mode, input logic [KEY_BITS-1:0] key,
                                   input logic [TAG_BITS-1:0] tag);
    smpq_in_t t;
    t.mode     = mode;
    t.item_key = key;
    t.item_tag = tag;
    offer_queue.push_back(t);
  endfunction

  function automatic logic [KEY_BITS-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return KEY_BITS'($urandom_range(0, 7));  // lots of ties
    if (sel == 4) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        2: return KEY_BITS'(1);
        default: return {{(KEY_BITS-1){1'b1}}, 1'b0};
      endcase
    end
    return KEY_BITS'($urandom_range(0, 65535));
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int idle_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sort_and_report(in_data);
        taken_count++;
      end
      if (!in_valid || in_ready) begin
        if (idle_left > 0 || offer_queue.size() == 0) begin
          if (idle_left > 0) idle_left--;
          in_valid <= 1'b0;
        end else begin
          in_data  <= offer_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(0, 15);
            idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Receiver: stall pattern is picked at random from four; two long hold-offs fill the pipe.
  int rx_cycle = 0;
  int rx_pattern = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 40 == 0) rx_pattern = $urandom_range(0, 3);
      if (rx_cycle == 400 || rx_cycle == 1200) hold_left = 300;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_pattern)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : monitor
    smpq_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (status_fifo.size() == 0) begin
        report_error($sformatf("result %0d arrived with no transaction pending",
                               result_index));
      end else begin
        want = status_fifo.pop_front();
        check_field("removed_valid", 32'(out_data.removed_valid), 32'(want.removed_valid));
        check_field("removed_key", 32'(out_data.removed_key), 32'(want.removed_key));
        check_field("removed_tag", 32'(out_data.removed_tag), 32'(want.removed_tag));
        check_field("head_valid", 32'(out_data.head_valid), 32'(want.head_valid));
        check_field("head_key", 32'(out_data.head_key), 32'(want.head_key));
        check_field("head_tag", 32'(out_data.head_tag), 32'(want.head_tag));
        check_field("entry_count", 32'(out_data.entry_count), 32'(want.entry_count));
        check_field("insert_dropped", 32'(out_data.insert_dropped),
                    32'(want.insert_dropped));
      end
      result_index++;
    end
  end

  initial begin
    int span;
    int ins_pct;
    int k;

    // Directed: pop on empty, extremes, ties, fill to capacity, drop, partial drain.
    add_item(MODE_REMOVE, '1, '1);
    add_item(MODE_INSERT, '1, '1);
    add_item(MODE_INSERT, '0, '0);
    add_item(MODE_INSERT, '0, 8'h01);
    add_item(MODE_INSERT, '0, 8'h02);
    add_item(MODE_INSERT, 16'h8000, 8'h80);
    add_item(MODE_INSERT, 16'h7fff, 8'h7f);
    add_item(MODE_INSERT, '1, 8'h55);
    for (k = 0; k < 8; k++) add_item(MODE_INSERT, 16'h0100 + 16'(k % 3), 8'(8'hA0 + k));
    add_item(MODE_INSERT, 16'h0001, 8'hAA);
    add_item(MODE_INSERT, '0, 8'hEE);
    for (k = 0; k < 6; k++) add_item(MODE_REMOVE, 16'(k * 16'h2AAB), 8'(k * 8'h33));

    // Random episodes that swing the fill level between empty and full.
    while (offer_queue.size() < 1100) begin
      case ($urandom_range(0, 3))
        0: ins_pct = 10;
        1: ins_pct = 50;
        2: ins_pct = 85;
        default: ins_pct = 100;
      endcase
      span = $urandom_range(10, 50);
      for (k = 0; k < span; k++) begin
        if ($urandom_range(1, 100) <= ins_pct)
          add_item(MODE_INSERT, pick_key(), TAG_BITS'($urandom_range(0, 255)));
        else
          add_item(MODE_REMOVE, KEY_BITS'($urandom), TAG_BITS'($urandom));
      end
    end
    total_items = offer_queue.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (taken_count < total_items) @(posedge clk);
    while (status_fifo.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
